### src/bda_pkg.sv
// Package: shared types and constants for the button debouncer with auto-repeat.
package bda_pkg;

    localparam int NUM_BUTTONS = 6;
    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [TICK_W-1:0] DEBOUNCE_RST     = 16'd5;
    localparam logic [TICK_W-1:0] FIRST_REPEAT_RST = 16'd50;
    localparam logic [TICK_W-1:0] REPEAT_RST       = 16'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_REPEAT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT       = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_PRESS_CAND   = 3'd1,
        ST_RELEASE_CAND = 3'd2,
        ST_WAIT_FIRST   = 3'd3,
        ST_REPEATING    = 3'd4
    } t_lane_state;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_RELEASED = 2'd1,
        EV_PRESSED  = 2'd2,
        EV_REPEAT   = 2'd3
    } t_event;

    typedef struct packed {
        logic [TICK_W-1:0] stable_ticks;
        logic [TICK_W-1:0] first_repeat_ticks;
        logic [TICK_W-1:0] repeat_ticks;
    } t_cfg;

    typedef struct packed {
        logic up_pressed;
        logic right_pressed;
        logic down_pressed;
        logic left_pressed;
        logic ok_pressed;
        logic cancel_pressed;
    } t_in_req;

    typedef struct packed {
        logic [1:0] up_event;
        logic [1:0] right_event;
        logic [1:0] down_event;
        logic [1:0] left_event;
        logic [1:0] ok_event;
        logic [1:0] cancel_event;
    } t_out_req;

endpackage

### src/bda_lane.sv
// Module: one button's debounce and auto-repeat state machine with its tick counter.
module bda_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_pressed,
    input  bda_pkg::t_cfg      i_cfg,
    output bda_pkg::t_event    o_event
);

    bda_pkg::t_lane_state             r_state;
    bda_pkg::t_lane_state             n_state;
    logic [bda_pkg::TICK_W-1:0]       r_cnt;
    logic [bda_pkg::TICK_W-1:0]       n_cnt;
    logic [bda_pkg::TICK_W-1:0]       w_cnt_inc;
    logic [bda_pkg::TICK_W-1:0]       w_target;
    logic [bda_pkg::TICK_W-1:0]       w_wait;
    logic                             w_hit_debounce;
    logic                             w_hit_wait;
    logic                             w_bounce;

    // Saturating count of this tick
    assign w_cnt_inc = (r_cnt == {bda_pkg::TICK_W{1'b1}}) ? r_cnt
                                                           : r_cnt + 1'b1;
    assign w_target  = i_cfg.stable_ticks - 1'b1;
    assign w_wait    = (r_state == bda_pkg::ST_WAIT_FIRST) ? i_cfg.first_repeat_ticks
                                                           : i_cfg.repeat_ticks;
    assign w_hit_debounce = (w_cnt_inc == w_target);
    assign w_hit_wait     = (w_cnt_inc == w_wait);
    assign w_bounce       = (i_pressed != (r_state == bda_pkg::ST_PRESS_CAND));

    // Next state and counter
    always_comb begin
        n_state = r_state;
        n_cnt   = w_cnt_inc;
        case (r_state)
            bda_pkg::ST_IDLE: begin
                if (i_pressed) begin
                    n_state = bda_pkg::ST_PRESS_CAND;
                    n_cnt   = '0;
                end
            end
            bda_pkg::ST_PRESS_CAND, bda_pkg::ST_RELEASE_CAND: begin
                if (w_bounce) begin
                    n_state = bda_pkg::ST_IDLE;
                    n_cnt   = '0;
                end else if (w_hit_debounce) begin
                    n_state = (r_state == bda_pkg::ST_RELEASE_CAND) ? bda_pkg::ST_IDLE
                                                                    : bda_pkg::ST_WAIT_FIRST;
                    n_cnt   = '0;
                end
            end
            bda_pkg::ST_WAIT_FIRST, bda_pkg::ST_REPEATING: begin
                if (!i_pressed) begin
                    n_state = bda_pkg::ST_RELEASE_CAND;
                    n_cnt   = '0;
                end else if (w_hit_wait) begin
                    n_state = bda_pkg::ST_REPEATING;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_state = r_state;
            end
        endcase
    end

    // Event of this tick
    always_comb begin
        o_event = bda_pkg::EV_NONE;
        case (r_state)
            bda_pkg::ST_PRESS_CAND: begin
                if (!w_bounce && w_hit_debounce) begin
                    o_event = bda_pkg::EV_PRESSED;
                end
            end
            bda_pkg::ST_RELEASE_CAND: begin
                if (!w_bounce && w_hit_debounce) begin
                    o_event = bda_pkg::EV_RELEASED;
                end
            end
            bda_pkg::ST_WAIT_FIRST, bda_pkg::ST_REPEATING: begin
                if (i_pressed && w_hit_wait) begin
                    o_event = bda_pkg::EV_REPEAT;
                end
            end
            default: begin
                o_event = bda_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bda_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else if (i_adv) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### src/button_debounce_autorepeat.sv
// Module: top level of the six-button debouncer with auto-repeat.
//
// Usage: each input request is one polling tick carrying the raw pressed level
// of six buttons (up, right, down, left, ok, cancel). The input channel takes a
// request at a clock edge where i_in_valid is high and o_in_stall is low.
// Every tick yields exactly one output request: six 2-bit event codes
// (none, released, pressed, repeat), one per button, in the same order.
// The result of an accepted tick is registered in the output or skid register.
// Throughput: one tick per cycle while o_in_stall is low. Each button's state
// and tick counter update in the same cycle the tick is accepted; the path is
// one saturating increment, a 16-bit compare and the next-state select.
// Back-pressure: an output register and a skid register sit on the result
// side. o_in_stall rises only when both hold results, so a tick is still
// taken on the cycle the receiver first stalls; held results never change.
// Reset (i_rst_n low, synchronous): every button returns to idle with a zero
// counter, the result buffers empty, and the registers take their defaults
// (debounce 5, first repeat 50, repeat 10). Write registers through
// i_cfg_we / i_cfg_idx / i_cfg_data only while the block is idle; index 3
// is ignored.
module button_debounce_autorepeat (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bda_pkg::t_in_req                  i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bda_pkg::t_out_req                 o_out_req,
    input  logic                              i_cfg_we,
    input  logic [bda_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bda_pkg::TICK_W-1:0]        i_cfg_data
);

    bda_pkg::t_cfg                     r_cfg;
    logic [bda_pkg::NUM_BUTTONS-1:0]   w_pressed;
    bda_pkg::t_event                   w_event [bda_pkg::NUM_BUTTONS];
    bda_pkg::t_out_req                 w_result;
    logic                              w_in_take;
    logic                              w_out_free;

    logic                              r_out_valid;
    bda_pkg::t_out_req                 r_out;
    logic                              r_skid_valid;
    bda_pkg::t_out_req                 r_skid;

    // Configuration registers: drop writes to unused indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_ticks       <= bda_pkg::DEBOUNCE_RST;
            r_cfg.first_repeat_ticks <= bda_pkg::FIRST_REPEAT_RST;
            r_cfg.repeat_ticks       <= bda_pkg::REPEAT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bda_pkg::CFG_DEBOUNCE:     r_cfg.stable_ticks       <= i_cfg_data;
                bda_pkg::CFG_FIRST_REPEAT: r_cfg.first_repeat_ticks <= i_cfg_data;
                bda_pkg::CFG_REPEAT:       r_cfg.repeat_ticks       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stall only when both result slots are occupied
    assign o_in_stall = r_skid_valid;
    assign w_in_take  = i_in_valid && !r_skid_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Button 0 is up, button 5 is cancel
    assign w_pressed = {i_in_req.cancel_pressed, i_in_req.ok_pressed,
                        i_in_req.left_pressed,   i_in_req.down_pressed,
                        i_in_req.right_pressed,  i_in_req.up_pressed};

    // One state machine per button; advance all of them on each accepted tick
    for (genvar g = 0; g < bda_pkg::NUM_BUTTONS; g++) begin : g_lane
        bda_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (w_in_take),
            .i_pressed (w_pressed[g]),
            .i_cfg     (r_cfg),
            .o_event   (w_event[g])
        );
    end

    assign w_result.up_event     = 2'(w_event[0]);
    assign w_result.right_event  = 2'(w_event[1]);
    assign w_result.down_event   = 2'(w_event[2]);
    assign w_result.left_event   = 2'(w_event[3]);
    assign w_result.ok_event     = 2'(w_event[4]);
    assign w_result.cancel_event = 2'(w_event[5]);

    // Result side: output register backed by one skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_in_take;
            end
        end else if (w_in_take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_in_take) begin
                r_out <= w_result;
            end
        end else if (w_in_take) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

### tb/tb_button_debounce_autorepeat.sv
// Self-checking testbench for the six-button debouncer with auto-repeat.
`timescale 1ns / 100ps

module tb_button_debounce_autorepeat;

    localparam int WATCHDOG_LIMIT = 1000;   // cycles with no request moving on either side
    localparam int LONG_HOLD      = 60;     // receiver hold-off used to back up the block
    localparam int SETTLE_CYCLES  = 5;      // margin after the last result before the verdict

    // Index 3 decodes to no register; writes there must be dropped.
    localparam logic [bda_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Short holds under the widest thresholds: debounce 0 (target 65535) and both
    // repeat delays at 65535, so no candidate confirms and no event comes out.
    localparam int HELD_TICKS     = 30;
    localparam int RELEASED_TICKS = 10;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    bda_pkg::t_in_req              i_in_req    = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    bda_pkg::t_out_req             o_out_req;
    logic                          i_cfg_we    = 1'b0;
    logic [bda_pkg::CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [bda_pkg::TICK_W-1:0]    i_cfg_data  = '0;

    button_debounce_autorepeat uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Handshake strobes; read at the rising edge they show the pre-edge values.
    wire in_fire  = i_rst_n && i_in_valid && !o_in_stall;
    wire out_fire = i_rst_n && o_out_valid && !i_out_stall;

    // Ticks waiting to be offered, and event words waiting to come back.
    bda_pkg::t_in_req  pending_ticks[$];
    bda_pkg::t_out_req expected_events[$];

    int mismatch_count = 0;
    bit idle_on        = 1'b1;   // random gaps and stalls allowed
    bit long_hold_arm  = 1'b0;   // receiver backs off once with the long hold-off
    bit long_hold_done = 1'b0;
    int gap_left       = 0;
    int stall_left     = 0;

    string event_name[bda_pkg::NUM_BUTTONS] = '{"up_event", "right_event", "down_event",
                                                "left_event", "ok_event", "cancel_event"};

    // ------------------------------------------------------------------
    // Shadow of the block: per-button machine state, tick counters and
    // register values. Button b sits at bit NUM_BUTTONS-1-b of the request,
    // since the first struct field is the most significant.
    // ------------------------------------------------------------------
    bda_pkg::t_lane_state       lane_st [bda_pkg::NUM_BUTTONS] = '{default: bda_pkg::ST_IDLE};
    logic [bda_pkg::TICK_W-1:0] lane_cnt[bda_pkg::NUM_BUTTONS] = '{default: '0};
    bda_pkg::t_cfg              cfg_model = '{bda_pkg::DEBOUNCE_RST,
                                              bda_pkg::FIRST_REPEAT_RST,
                                              bda_pkg::REPEAT_RST};

    // Advance every button by one tick and return the event word it yields.
    function automatic bda_pkg::t_out_req predict_events(input bda_pkg::t_in_req req);
        logic [bda_pkg::NUM_BUTTONS-1:0]   lvl;
        logic [2*bda_pkg::NUM_BUTTONS-1:0] ev;
        logic [bda_pkg::TICK_W-1:0]        target;
        logic [bda_pkg::TICK_W-1:0]        delay;
        logic                              pressed;
        bda_pkg::t_event                   e;
        lvl    = req;
        ev     = '0;
        target = cfg_model.stable_ticks - 16'd1;   // wraps to 65535 for zero
        for (int b = 0; b < bda_pkg::NUM_BUTTONS; b++) begin
            pressed = lvl[bda_pkg::NUM_BUTTONS-1-b];
            e       = bda_pkg::EV_NONE;
            // Count first, saturating; a state change below clears the count.
            if (lane_cnt[b] != '1)
                lane_cnt[b] = lane_cnt[b] + 16'd1;
            case (lane_st[b])
                bda_pkg::ST_IDLE: begin
                    if (pressed) begin
                        lane_st[b]  = bda_pkg::ST_PRESS_CAND;
                        lane_cnt[b] = '0;
                    end
                end
                bda_pkg::ST_PRESS_CAND, bda_pkg::ST_RELEASE_CAND: begin
                    if (pressed != (lane_st[b] == bda_pkg::ST_PRESS_CAND)) begin
                        // Level moved before it was confirmed: a bounce.
                        lane_st[b]  = bda_pkg::ST_IDLE;
                        lane_cnt[b] = '0;
                    end else if (lane_cnt[b] == target) begin
                        if (lane_st[b] == bda_pkg::ST_RELEASE_CAND) begin
                            e          = bda_pkg::EV_RELEASED;
                            lane_st[b] = bda_pkg::ST_IDLE;
                        end else begin
                            e          = bda_pkg::EV_PRESSED;
                            lane_st[b] = bda_pkg::ST_WAIT_FIRST;
                        end
                        lane_cnt[b] = '0;
                    end
                end
                bda_pkg::ST_WAIT_FIRST, bda_pkg::ST_REPEATING: begin
                    delay = (lane_st[b] == bda_pkg::ST_WAIT_FIRST) ?
                            cfg_model.first_repeat_ticks : cfg_model.repeat_ticks;
                    if (!pressed) begin
                        lane_st[b]  = bda_pkg::ST_RELEASE_CAND;
                        lane_cnt[b] = '0;
                    end else if (lane_cnt[b] == delay) begin
                        e           = bda_pkg::EV_REPEAT;
                        lane_st[b]  = bda_pkg::ST_REPEATING;
                        lane_cnt[b] = '0;
                    end
                end
                default: ;
            endcase
            ev[2*(bda_pkg::NUM_BUTTONS-1-b) +: 2] = e;
        end
        return bda_pkg::t_out_req'(ev);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued ticks, hold a stalled request, and insert random
    // gaps after a request when idling is enabled.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_fire)
                expected_events.push_back(predict_events(i_in_req));
            // Hold the payload while the block stalls it.
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_ticks.size() != 0) begin
                    i_in_req   <= pending_ticks.pop_front();
                    i_in_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(1, 9);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation,
    // then pick the stall for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        bda_pkg::t_out_req want;
        bda_pkg::t_out_req seen;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (out_fire) begin
                seen = o_out_req;
                if (expected_events.size() == 0) begin
                    $error("result %h arrived with no tick outstanding", seen);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    for (int b = 0; b < bda_pkg::NUM_BUTTONS; b++) begin
                        if (seen[2*(bda_pkg::NUM_BUTTONS-1-b) +: 2] !==
                            want[2*(bda_pkg::NUM_BUTTONS-1-b) +: 2]) begin
                            $error("%s: expected %0d, actual %0d", event_name[b],
                                   want[2*(bda_pkg::NUM_BUTTONS-1-b) +: 2],
                                   seen[2*(bda_pkg::NUM_BUTTONS-1-b) +: 2]);
                            mismatch_count++;
                        end
                    end
                end
                // Back off hard once so both result registers fill and the
                // block pushes back on its input.
                if (long_hold_arm && !long_hold_done) begin
                    stall_left     = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 8);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // End the run if nothing moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (in_fire || out_fire)
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    int run_left [bda_pkg::NUM_BUTTONS] = '{default: 0};
    bit btn_level[bda_pkg::NUM_BUTTONS] = '{default: 1'b0};

    // Write one register while the block is idle and mirror it in the shadow.
    task automatic write_reg(input logic [bda_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bda_pkg::TICK_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            bda_pkg::CFG_DEBOUNCE:     cfg_model.stable_ticks       = val;
            bda_pkg::CFG_FIRST_REPEAT: cfg_model.first_repeat_ticks = val;
            bda_pkg::CFG_REPEAT:       cfg_model.repeat_ticks       = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Hold the sender until every queued tick has gone in and every result is back.
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || expected_events.size() != 0)
            @(negedge i_clk);
    endtask

    // Queue n ticks of press/release runs per button, sized to the current
    // setup: most runs are long enough to confirm, the longer ones to repeat;
    // some are short bounces, and a few ticks are pure noise across all buttons.
    task automatic queue_button_runs(input int n);
        logic [bda_pkg::NUM_BUTTONS-1:0] lvl;
        int db;
        int span;
        db = (cfg_model.stable_ticks < 2)  ? 2  :
             (cfg_model.stable_ticks > 40) ? 40 : int'(cfg_model.stable_ticks);
        span = db + 2
             + ((cfg_model.first_repeat_ticks > 60) ? 60 : int'(cfg_model.first_repeat_ticks))
             + 3 * ((cfg_model.repeat_ticks > 20) ? 20 : int'(cfg_model.repeat_ticks));
        for (int i = 0; i < n; i++) begin
            for (int b = 0; b < bda_pkg::NUM_BUTTONS; b++) begin
                if (run_left[b] == 0) begin
                    btn_level[b] = ~btn_level[b];
                    if ($urandom_range(0, 4) == 0)
                        run_left[b] = $urandom_range(1, db);
                    else
                        run_left[b] = $urandom_range(db, span);
                end
                run_left[b]--;
                lvl[bda_pkg::NUM_BUTTONS-1-b] = btn_level[b];
            end
            if ($urandom_range(0, 19) == 0)
                lvl = bda_pkg::NUM_BUTTONS'($urandom);
            pending_ticks.push_back(bda_pkg::t_in_req'(lvl));
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        logic [bda_pkg::NUM_BUTTONS-1:0] directed[$];
        directed = '{6'b000000, 6'b111111, 6'b111111, 6'b111111, 6'b111111,
                     6'b111100, 6'b101010, 6'b101010, 6'b010101, 6'b010101,
                     6'b010101, 6'b100001, 6'b100001, 6'b011110, 6'b011110,
                     6'b000000, 6'b000000, 6'b111111, 6'b000000, 6'b111111,
                     6'b111111, 6'b000000, 6'b000000};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: debounce 5, first repeat 50, repeat 10.
        queue_button_runs(150);
        wait_drained();

        // Shortest delays so the directed ticks confirm, repeat, bounce and release.
        write_reg(bda_pkg::CFG_DEBOUNCE, 16'd2);
        write_reg(bda_pkg::CFG_FIRST_REPEAT, 16'd1);
        write_reg(bda_pkg::CFG_REPEAT, 16'd1);
        foreach (directed[i])
            pending_ticks.push_back(bda_pkg::t_in_req'(directed[i]));
        wait_drained();

        // Debounce 1 has a zero target: candidates hold until a bounce.
        write_reg(bda_pkg::CFG_DEBOUNCE, 16'd1);
        queue_button_runs(80);
        wait_drained();

        // Zero repeat delays never fire: held buttons stay silent.
        write_reg(bda_pkg::CFG_DEBOUNCE, 16'd3);
        write_reg(bda_pkg::CFG_FIRST_REPEAT, 16'd0);
        write_reg(bda_pkg::CFG_REPEAT, 16'd0);
        queue_button_runs(100);
        wait_drained();

        // A write to the unused index must change nothing.
        write_reg(CFG_UNUSED, 16'hFFFF);
        write_reg(bda_pkg::CFG_FIRST_REPEAT, 16'd4);
        queue_button_runs(60);
        wait_drained();

        // Random setups with small delays so events come often.
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(bda_pkg::CFG_DEBOUNCE, 16'($urandom_range(2, 6)));
            write_reg(bda_pkg::CFG_FIRST_REPEAT, 16'($urandom_range(0, 8)));
            write_reg(bda_pkg::CFG_REPEAT, 16'($urandom_range(0, 4)));
            idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 2) begin
                idle_on       = 1'b1;
                long_hold_arm = 1'b1;
            end
            queue_button_runs(90);
            // Pause the sender mid-phase until every result is back.
            wait_drained();
            queue_button_runs(90);
            wait_drained();
        end

        // Last part, no idling: largest thresholds. Debounce 0 wraps to a
        // 65535 target, so these short holds never confirm.
        idle_on = 1'b0;
        write_reg(bda_pkg::CFG_DEBOUNCE, 16'd0);
        write_reg(bda_pkg::CFG_FIRST_REPEAT, 16'hFFFF);
        write_reg(bda_pkg::CFG_REPEAT, 16'hFFFF);
        for (int i = 0; i < HELD_TICKS; i++)
            pending_ticks.push_back(bda_pkg::t_in_req'({bda_pkg::NUM_BUTTONS{1'b1}}));
        for (int i = 0; i < RELEASED_TICKS; i++)
            pending_ticks.push_back(bda_pkg::t_in_req'({bda_pkg::NUM_BUTTONS{1'b0}}));
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### files.f
src/bda_pkg.sv
src/bda_lane.sv
src/button_debounce_autorepeat.sv
tb/tb_button_debounce_autorepeat.sv
